// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque: operation and status codes, the command and
// response structs, and the sequencer state type. It has no dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

    // Operation codes carried in the command field op.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

    // Response status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    // Data returned by a peek on an empty deque.
    localparam logic signed [31:0] DATA_EMPTY_PEEK = -32'sd1;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_cdq_cmd;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               is_full;
        logic               is_empty;
    } t_cdq_rsp;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_cdq_state;

endpackage

// ----- rtl/cdq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by the deque core for its entry storage.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/circular_deque_core.sv -----
// Top level of the circular deque: index and occupancy registers, the
// operation sequencer and the response register. Depends on cdq_pkg and cdq_ram.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                    Payload
//  command   in         i_cmd_valid / o_cmd_stall    i_cmd (t_cdq_cmd)
//  response  out        o_rsp_valid / i_rsp_stall    o_rsp (t_cdq_rsp)
//
// For pushes, pops, failed peeks and unused codes the response is
// registered at the edge that accepts the command.
// A peek of a held entry waits in S_READ for the registered read of the
// storage RAM; no command is accepted while in S_READ.
// Reset (synchronous, active low) empties the deque and drops any response;
// the storage itself is not cleared, so no clearing pass is needed.
// A stalled response holds; a new command is taken in the same cycle as the
// waiting response leaves.

module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    output logic     o_cmd_stall,
    input  t_cdq_cmd i_cmd,
    output logic     o_rsp_valid,
    input  logic     i_rsp_stall,
    output t_cdq_rsp o_rsp
);

    // Index width covers DEPTH entries; the occupancy must also hold DEPTH.
    localparam int IW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
    localparam logic [OW-1:0] OCC_FULL = OW'(DEPTH);

    t_cdq_state    r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [OW-1:0] r_occ, n_occ;
    logic          r_rsp_valid, n_rsp_valid;
    t_cdq_rsp      r_rsp, n_rsp;

    logic          rsp_free;
    logic          cmd_fire;
    logic          rsp_load;
    logic          is_full;
    logic          is_empty;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [IW-1:0] tail_dec;
    logic [IW-1:0] tail_inc;

    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;
    logic          ram_rd_en;
    logic [IW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    // The response slot is free when empty or when its contents leave now.
    // Only the idle state takes commands, so a peek's RAM read never meets
    // a write to the same entry in the same cycle.
    assign rsp_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_cmd_stall = !((r_state == S_IDLE) && rsp_free);
    assign cmd_fire    = i_cmd_valid && !o_cmd_stall;

    assign is_full  = (r_occ == OCC_FULL);
    assign is_empty = (r_occ == '0);

    // Wrap-around index steps.
    assign head_dec = (r_head == '0)       ? IDX_LAST : r_head - 1'b1;
    assign head_inc = (r_head == IDX_LAST) ? '0       : r_head + 1'b1;
    assign tail_dec = (r_tail == '0)       ? IDX_LAST : r_tail - 1'b1;
    assign tail_inc = (r_tail == IDX_LAST) ? '0       : r_tail + 1'b1;

    cdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_cdq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        rsp_load    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = (i_cmd.op == OP_PEEK_FRONT) ? r_head : r_tail;
        n_rsp       = r_rsp;

        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_rsp.data   = '0;
                    n_rsp.status = STAT_OK;
                    rsp_load     = 1'b1;
                    case (i_cmd.op) inside
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            if (is_full) begin
                                n_rsp.status = STAT_OVERFLOW;
                            end else begin
                                ram_wr_en = 1'b1;
                                n_occ     = r_occ + 1'b1;
                                // A push into an empty deque restarts at entry zero.
                                if (is_empty) begin
                                    n_head      = '0;
                                    n_tail      = '0;
                                    ram_wr_addr = '0;
                                end else if (i_cmd.op == OP_PUSH_FRONT) begin
                                    n_head      = head_dec;
                                    ram_wr_addr = head_dec;
                                end else begin
                                    n_tail      = tail_inc;
                                    ram_wr_addr = tail_inc;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR: begin
                            if (is_empty) begin
                                n_rsp.status = STAT_UNDERFLOW;
                            end else begin
                                n_occ = r_occ - 1'b1;
                                // Popping the last entry leaves the indices alone.
                                if (r_occ != OW'(1)) begin
                                    if (i_cmd.op == OP_POP_FRONT) begin
                                        n_head = head_inc;
                                    end else begin
                                        n_tail = tail_dec;
                                    end
                                end
                            end
                        end
                        OP_PEEK_FRONT, OP_PEEK_REAR: begin
                            if (is_empty) begin
                                n_rsp.status = STAT_UNDERFLOW;
                                n_rsp.data   = DATA_EMPTY_PEEK;
                            end else begin
                                // Wait in S_READ for the registered RAM read data.
                                ram_rd_en = 1'b1;
                                rsp_load  = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rsp.data   = ram_rd_data;
                n_rsp.status = STAT_OK;
                rsp_load     = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Flags describe the occupancy after the operation.
        n_rsp.is_full  = (n_occ == OCC_FULL);
        n_rsp.is_empty = (n_occ == '0);

        if (rsp_load) begin
            n_rsp_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- rtl/cdq_checker.sv -----
// Port-level checker for the circular deque core and the bind that attaches
// it. Depends on cdq_pkg and on circular_deque_core.
`timescale 1ns / 1ps

module cdq_port_checker
    import cdq_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_cmd_valid,
    input logic     o_cmd_stall,
    input t_cdq_cmd i_cmd,
    input logic     o_rsp_valid,
    input logic     i_rsp_stall,
    input t_cdq_rsp o_rsp
);

    // A stalled response transaction holds its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // The deque cannot be full and empty at once.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.is_full && o_rsp.is_empty))
        else $error("response is both full and empty");

    // Overflow only happens on a full deque, underflow only on an empty one.
    a_status_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> ((o_rsp.status != STAT_OVERFLOW) || o_rsp.is_full) &&
                        ((o_rsp.status != STAT_UNDERFLOW) || o_rsp.is_empty))
        else $error("status disagrees with flags");

    // Any push leaves the deque non-empty, and its response follows at once.
    a_push_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !o_cmd_stall &&
        ((i_cmd.op == OP_PUSH_FRONT) || (i_cmd.op == OP_PUSH_REAR))
        |=> o_rsp_valid && !o_rsp.is_empty)
        else $error("push response missing or empty");

endmodule

bind circular_deque_core cdq_port_checker u_cdq_port_checker (.*);

// ----- dv/cdq_checker.sv -----
`timescale 1ns / 1ps
// Checker for circular_deque_core. It watches both channels, predicts each response
// and compares it field by field. Depends on cdq_pkg only.

module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    input  logic     i_cmd_stall,
    input  t_cdq_cmd i_cmd,
    input  logic     i_rsp_valid,
    input  logic     i_rsp_stall,
    input  t_cdq_rsp i_rsp,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [31:0] deque_words [DEPTH];
    logic [IDX_W-1:0]   front_idx;
    logic [IDX_W-1:0]   rear_idx;
    logic [CNT_W-1:0]   held_count;
    t_cdq_rsp           awaited_rsps [$];
    int                 mismatches = 0;

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] idx);
        return (idx == 0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Applies one command to the shadow deque and returns the response it yields.
    function automatic t_cdq_rsp deque_apply(input t_cdq_cmd cmd);
        t_cdq_rsp rsp;
        logic     was_full;
        logic     was_empty;
        rsp       = '0;
        was_full  = (held_count == DEPTH);
        was_empty = (held_count == 0);
        case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (was_full) begin
                    rsp.status = STAT_OVERFLOW;
                end else begin
                    if (was_empty) begin
                        front_idx      = '0;
                        rear_idx       = '0;
                        deque_words[0] = cmd.value;
                    end else if (cmd.op == OP_PUSH_FRONT) begin
                        front_idx              = idx_down(front_idx);
                        deque_words[front_idx] = cmd.value;
                    end else begin
                        rear_idx              = idx_up(rear_idx);
                        deque_words[rear_idx] = cmd.value;
                    end
                    held_count = held_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (was_empty) begin
                    rsp.status = STAT_UNDERFLOW;
                end else begin
                    // Removing the last entry leaves both indices where they are.
                    if (held_count > 1) begin
                        if (cmd.op == OP_POP_FRONT) begin
                            front_idx = idx_up(front_idx);
                        end else begin
                            rear_idx = idx_down(rear_idx);
                        end
                    end
                    held_count = held_count - 1'b1;
                end
            end
            OP_PEEK_FRONT, OP_PEEK_REAR: begin
                if (was_empty) begin
                    rsp.status = STAT_UNDERFLOW;
                    rsp.data   = DATA_EMPTY_PEEK;
                end else begin
                    rsp.data = (cmd.op == OP_PEEK_FRONT) ? deque_words[front_idx]
                                                         : deque_words[rear_idx];
                end
            end
            default: begin
            end
        endcase
        rsp.is_full  = (held_count == DEPTH);
        rsp.is_empty = (held_count == 0);
        return rsp;
    endfunction

    always @(posedge i_clk) begin : track
        t_cdq_rsp want;
        if (!i_rst_n) begin
            front_idx  = '0;
            rear_idx   = '0;
            held_count = '0;
            awaited_rsps.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (awaited_rsps.size() == 0) begin
                    $error("response with none outstanding: data %0d status %0d",
                           i_rsp.data, i_rsp.status);
                    mismatches++;
                end else begin
                    want = awaited_rsps.pop_front();
                    if (i_rsp.data !== want.data) begin
                        $error("data: expected %0d, actual %0d", want.data, i_rsp.data);
                        mismatches++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_rsp.status);
                        mismatches++;
                    end
                    if (i_rsp.is_full !== want.is_full) begin
                        $error("is_full: expected %0d, actual %0d", want.is_full, i_rsp.is_full);
                        mismatches++;
                    end
                    if (i_rsp.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, i_rsp.is_empty);
                        mismatches++;
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                awaited_rsps.push_back(deque_apply(i_cmd));
            end
        end
        o_pending    = awaited_rsps.size();
        o_fail_count = mismatches;
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for circular_deque_core: clock, reset, command stimulus, response
// back-pressure, watchdog and verdict. Depends on cdq_pkg, circular_deque_core, cdq_checker.

module tb_top;
    import cdq_pkg::*;

    localparam int DEPTH          = 16;
    // Number of random commands that actually exercise the deque.
    localparam int RANDOM_OPS     = 1100;
    // Length of the one long response hold-off, in cycles.
    localparam int LONG_HOLD      = 60;
    // The slowest correct stretch without a transaction is the long hold-off plus a
    // peek and the random stalls beside it. The limit leaves a wide margin over that.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to wait after the last response, a margin over the peek's wait in S_READ.
    localparam int SETTLE_CYCLES  = 10;

    // Op codes the package leaves unnamed; the block must ignore them.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cmd_valid;
    logic     o_cmd_stall;
    t_cdq_cmd i_cmd;
    logic     o_rsp_valid;
    logic     i_rsp_stall;
    t_cdq_rsp o_rsp;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic hold_off_req;

    circular_deque_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(i_cmd_valid),
        .o_cmd_stall(o_cmd_stall),
        .i_cmd      (i_cmd),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp)
    );

    cdq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .i_cmd_stall (o_cmd_stall),
        .i_cmd       (i_cmd),
        .i_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_rsp       (o_rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 12 ns period, starting low so the first rising edge is clean.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // The watchdog counts cycles in which neither channel completes a transaction.
    // A hung block or a lost response ends the run here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_cmd_valid && !o_cmd_stall) || (o_rsp_valid && !i_rsp_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Sender idle time: mostly back to back, often a short gap, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    // Push words are fully random, with the signed extremes and the all-zero and
    // all-one patterns mixed in so that the corners show up often.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // The op mix of a burst decides where the deque drifts: fill bursts run it into
    // overflow, drain bursts into underflow, even bursts wander in between.
    function automatic logic [2:0] pick_op(input t_mix mix);
        int   r;
        logic front;
        r     = $urandom_range(0, 99);
        front = 1'($urandom_range(0, 1));
        if (mix == MIX_EVEN) begin
            if (r < 3) begin
                return front ? OP_SPARE_6 : OP_SPARE_7;
            end
            r = $urandom_range(0, 2) * 40;
        end else if (mix == MIX_DRAIN) begin
            r = (r < 70) ? 40 : ((r < 85) ? 0 : 80);
        end else begin
            r = (r < 70) ? 0 : ((r < 85) ? 40 : 80);
        end
        if (r == 0) begin
            return front ? OP_PUSH_FRONT : OP_PUSH_REAR;
        end else if (r == 40) begin
            return front ? OP_POP_FRONT : OP_POP_REAR;
        end
        return front ? OP_PEEK_FRONT : OP_PEEK_REAR;
    endfunction

    // Offers one command from a falling edge and holds it until a rising edge takes it.
    // On return we sit on a falling edge; with a zero gap the valid stays high so the
    // next command follows without a bubble.
    task automatic send_op(input logic [2:0] code, input logic signed [31:0] word,
                           input int gap);
        t_cdq_cmd c;
        c.op        = code;
        c.value     = word;
        i_cmd_valid <= 1'b1;
        i_cmd       <= c;
        do begin
            @(posedge i_clk);
        end while (o_cmd_stall);
        @(negedge i_clk);
        if (gap > 0) begin
            // The payload is scrambled while idle; the block must not look at it.
            i_cmd_valid <= 1'b0;
            i_cmd       <= t_cdq_cmd'({$urandom, $urandom});
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Response side back-pressure. Each stretch has a level and a length, ranging
    // from long stall-free runs to long stalls. The first request for a hold-off
    // cuts the current stretch short and stalls for the long hold-off, so the response
    // register stays full and the block has to push back on its command input.
    initial begin : rsp_backpressure
        int   left;
        int   r;
        logic level;
        logic held_long;
        left        = 0;
        level       = 1'b0;
        held_long   = 1'b0;
        i_rsp_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !held_long) begin
                held_long = 1'b1;
                level     = 1'b1;
                left      = LONG_HOLD;
            end else if (left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    level = 1'b0;
                    left  = $urandom_range(30, 120);
                end else if (r < 60) begin
                    level = 1'b0;
                    left  = $urandom_range(1, 4);
                end else if (r < 92) begin
                    level = 1'b1;
                    left  = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    left  = $urandom_range(4, 20);
                end
            end
            i_rsp_stall <= level;
            left--;
        end
    end

    // Command stimulus: reset, a directed opening, then random bursts.
    initial begin : cmd_stimulus
        int       items;
        int       burst;
        logic     steady;
        logic     hold_asked;
        logic     pause_done;
        logic [2:0] code;
        t_mix     mix;
        i_rst_n      = 1'b0;
        i_cmd_valid  = 1'b0;
        i_cmd        = '0;
        hold_off_req = 1'b0;
        hold_asked   = 1'b0;
        pause_done   = 1'b0;
        items        = 0;
        // Reset is held low from the start, then released on a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Everything on an empty deque underflows; the spare code must be ignored.
        send_op(OP_PEEK_FRONT, 32'sh1234_5678, idle_gap());
        send_op(OP_PEEK_REAR, 32'sh0, idle_gap());
        send_op(OP_POP_FRONT, 32'sh0, idle_gap());
        send_op(OP_POP_REAR, 32'shffff_ffff, idle_gap());
        send_op(OP_SPARE_6, 32'sh5555_5555, idle_gap());
        // A front push into the empty deque lands in entry 0; the next front push
        // steps the head below zero and wraps it to the top entry.
        send_op(OP_PUSH_FRONT, 32'sh8000_0000, idle_gap());
        send_op(OP_PEEK_FRONT, 32'sh0, idle_gap());
        send_op(OP_PUSH_FRONT, 32'sh7fff_ffff, idle_gap());
        send_op(OP_PEEK_FRONT, 32'sh0, idle_gap());
        send_op(OP_PEEK_REAR, 32'sh0, idle_gap());
        send_op(OP_PUSH_REAR, 32'shffff_ffff, idle_gap());
        send_op(OP_PUSH_REAR, 32'sh0, idle_gap());
        send_op(OP_PEEK_REAR, 32'sh0, idle_gap());
        send_op(OP_SPARE_7, 32'shaaaa_aaaa, idle_gap());
        send_op(OP_POP_REAR, 32'sh0, idle_gap());
        // Popping the front steps the head from the top entry back to zero.
        send_op(OP_POP_FRONT, 32'sh0, idle_gap());
        send_op(OP_PEEK_FRONT, 32'sh0, idle_gap());
        send_op(OP_POP_FRONT, 32'sh0, idle_gap());
        // This pop removes the last entry; the peek after it must underflow.
        send_op(OP_POP_FRONT, 32'sh0, idle_gap());
        send_op(OP_PEEK_REAR, 32'sh0, idle_gap());
        // A rear push into the emptied deque again starts at entry 0.
        send_op(OP_PUSH_REAR, 32'sh5a5a_a5a5, idle_gap());
        send_op(OP_PEEK_FRONT, 32'sh0, idle_gap());
        send_op(OP_POP_REAR, 32'sh0, idle_gap());

        while (items < RANDOM_OPS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mix = MIX_FILL;
                4, 5, 6:    mix = MIX_DRAIN;
                default:    mix = MIX_EVEN;
            endcase
            burst  = $urandom_range(8, 40);
            steady = ($urandom_range(0, 3) == 0);
            // Once, ask the response side for its long hold-off and keep offering
            // commands back to back, so the block fills and stalls its input.
            if (!hold_asked && items >= 350) begin
                hold_asked   = 1'b1;
                hold_off_req <= 1'b1;
                mix          = MIX_FILL;
                steady       = 1'b1;
                burst        = 40;
            end
            // Once, go quiet until every outstanding response has come back.
            if (!pause_done && items >= 750) begin
                pause_done  = 1'b1;
                i_cmd_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            repeat (burst) begin
                code = pick_op(mix);
                send_op(code, pick_word(), steady ? 0 : idle_gap());
                if (code != OP_SPARE_6 && code != OP_SPARE_7) begin
                    items++;
                end
            end
        end

        // Let every response drain, then give stray responses time to show up.
        i_cmd_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
